// ===== rtl/lcpe_pkg.sv =====
`default_nettype none
package lcpe_pkg;

    localparam int ENTRIES   = 16;
    localparam int PIN_SLOTS = 16;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W     = 32;
    localparam int CAP_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIVE    = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;
    localparam logic [KEY_W-1:0] ALIVE_RESET = 32'd300;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_TICK   = 2'd1,
        OP_PIN    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_HIT       = 3'd0,
        KIND_MISS      = 3'd1,
        KIND_NO_ROOM   = 3'd2,
        KIND_EXPIRED   = 3'd3,
        KIND_TICK_NONE = 3'd4,
        KIND_PINNED    = 3'd5,
        KIND_PIN_FULL  = 3'd6,
        KIND_CLEARED   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MISS,
        ST_TICK,
        ST_PIN,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

endpackage
`default_nettype wire

// ===== rtl/lcpe_front.sv =====
`default_nettype none
module lcpe_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 opcode,
    input  wire logic [lcpe_pkg::KEY_W-1:0] key,
    input  wire logic [lcpe_pkg::KEY_W-1:0] now,
    output lcpe_pkg::queue_out_t            q_out,
    input  wire logic                       q_ready
);

    lcpe_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push, pop;
    lcpe_pkg::item_t in_item;

    // classify the incoming word
    always_comb
    begin
        in_item.op  = lcpe_pkg::op_t'(opcode);
        in_item.key = key;
        in_item.now = now;
    end

    assign in_ready     = (cnt_reg != 2'd2);
    assign push         = in_valid && in_ready;
    assign q_out.valid  = (cnt_reg != 2'd0);
    assign q_out.item   = mem_reg[rd_ptr_reg];
    assign pop          = q_out.valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lcpe_back.sv =====
`default_nettype none
module lcpe_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lcpe_pkg::queue_out_t           q_in,
    output logic                                q_ready,
    input  wire logic                           cfg_we,
    input  wire logic [lcpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lcpe_pkg::KEY_W-1:0]     cfg_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          result_kind,
    output logic [lcpe_pkg::KEY_W-1:0]          result_key,
    output logic                                evicted_valid,
    output logic [lcpe_pkg::KEY_W-1:0]          evicted_key,
    output logic                                last
);

    localparam int N  = lcpe_pkg::ENTRIES;
    localparam int P  = lcpe_pkg::PIN_SLOTS;
    localparam int IW = lcpe_pkg::IDX_W;
    localparam int CW = lcpe_pkg::CNT_W;
    localparam int KW = lcpe_pkg::KEY_W;

    // entry store
    logic [KW-1:0] key_reg   [N];
    logic [KW-1:0] key_next  [N];
    logic [KW-1:0] stamp_reg [N];
    logic [KW-1:0] stamp_next[N];
    logic [IW-1:0] rank_reg  [N];
    logic [IW-1:0] rank_next [N];
    logic [N-1:0]  valid_reg, valid_next;
    logic [N-1:0]  epin_reg, epin_next;
    logic [CW-1:0] count_reg, count_next;

    // pin table
    logic [KW-1:0] pkey_reg  [P];
    logic [KW-1:0] pkey_next [P];
    logic [P-1:0]  pvalid_reg, pvalid_next;

    logic [lcpe_pkg::CAP_W-1:0] cap_reg;
    logic [KW-1:0]              alive_reg;

    lcpe_pkg::state_t state_reg, state_next;
    lcpe_pkg::item_t  cur_reg, cur_next;
    logic [CW-1:0]    r_reg, r_next;
    logic [CW-1:0]    end_reg, end_next;
    logic [CW-1:0]    keep_reg, keep_next;
    logic             pend_reg, pend_next;
    logic [KW-1:0]    pend_key_reg, pend_key_next;

    logic             out_valid_reg, out_valid_next;
    lcpe_pkg::kind_t  kind_reg, kind_next;
    logic [KW-1:0]    rkey_reg, rkey_next;
    logic             ev_reg, ev_next;
    logic [KW-1:0]    evkey_reg, evkey_next;
    logic             last_reg, last_next;

    logic [N-1:0]  hit, cand, victim, tsel;
    logic          hit_any, victim_any, free_any, tpin, expired, out_free;
    logic [IW-1:0] hit_rank, victim_rank, free_idx;
    logic [KW-1:0] victim_key, tkey, tstamp, limit;
    logic [P-1:0]  pin_match;
    logic          pin_hit, pin_free_any;
    logic [$clog2(P+1)-1:0] pin_free_idx;
    logic [CW-1:0] cap_eff;

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign result_key    = rkey_reg;
    assign evicted_valid = ev_reg;
    assign evicted_key   = evkey_reg;
    assign last          = last_reg;
    assign out_free      = !out_valid_reg || out_ready;
    assign q_ready       = (state_reg == lcpe_pkg::ST_IDLE);

    // associative lookups, all in parallel
    always_comb
    begin
        hit_any     = 1'b0;
        hit_rank    = '0;
        free_any    = 1'b0;
        free_idx    = '0;
        victim_any  = 1'b0;
        victim_rank = '0;
        victim_key  = '0;
        tpin        = 1'b0;
        tkey        = '0;
        tstamp      = '0;
        for (int i = 0; i < N; i++)
        begin
            hit[i]  = valid_reg[i] && (key_reg[i] == cur_reg.key);
            cand[i] = valid_reg[i] && !epin_reg[i];
            tsel[i] = valid_reg[i] && (rank_reg[i] == r_reg[IW-1:0]);
        end
        for (int i = 0; i < N; i++)
        begin
            victim[i] = cand[i];
            for (int j = 0; j < N; j++)
            begin
                if (cand[j] && (rank_reg[j] > rank_reg[i]))
                begin
                    victim[i] = 1'b0;
                end
            end
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
        for (int i = 0; i < N; i++)
        begin
            hit_any     = hit_any | hit[i];
            hit_rank    = hit_rank | (rank_reg[i] & {IW{hit[i]}});
            victim_any  = victim_any | victim[i];
            victim_rank = victim_rank | (rank_reg[i] & {IW{victim[i]}});
            victim_key  = victim_key | (key_reg[i] & {KW{victim[i]}});
            tpin        = tpin | (epin_reg[i] & tsel[i]);
            tkey        = tkey | (key_reg[i] & {KW{tsel[i]}});
            tstamp      = tstamp | (stamp_reg[i] & {KW{tsel[i]}});
        end
        pin_hit      = 1'b0;
        pin_free_any = 1'b0;
        pin_free_idx = '0;
        for (int p = 0; p < P; p++)
        begin
            pin_match[p] = pvalid_reg[p] && (pkey_reg[p] == cur_reg.key);
            pin_hit      = pin_hit | pin_match[p];
        end
        for (int p = P - 1; p >= 0; p--)
        begin
            if (!pvalid_reg[p])
            begin
                pin_free_any = 1'b1;
                pin_free_idx = ($clog2(P+1))'(p);
            end
        end
        limit   = tstamp + alive_reg;
        expired = (|tsel) && (limit < cur_reg.now) && !tpin;
        cap_eff = (32'(cap_reg) > 32'(N)) ? CW'(N) : CW'(cap_reg);
    end

    always_comb
    begin
        key_next       = key_reg;
        stamp_next     = stamp_reg;
        rank_next      = rank_reg;
        valid_next     = valid_reg;
        epin_next      = epin_reg;
        count_next     = count_reg;
        pkey_next      = pkey_reg;
        pvalid_next    = pvalid_reg;
        state_next     = state_reg;
        cur_next       = cur_reg;
        r_next         = r_reg;
        end_next       = end_reg;
        keep_next      = keep_reg;
        pend_next      = pend_reg;
        pend_key_next  = pend_key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        rkey_next      = rkey_reg;
        ev_next        = ev_reg;
        evkey_next     = evkey_reg;
        last_next      = last_reg;

        case (state_reg)
            lcpe_pkg::ST_IDLE:
            begin
                if (q_in.valid)
                begin
                    cur_next = q_in.item;
                    case (q_in.item.op)
                        lcpe_pkg::OP_ACCESS: state_next = lcpe_pkg::ST_ACC;
                        lcpe_pkg::OP_TICK:
                        begin
                            r_next     = '0;
                            end_next   = count_reg;
                            keep_next  = '0;
                            pend_next  = 1'b0;
                            state_next = lcpe_pkg::ST_TICK;
                        end
                        lcpe_pkg::OP_PIN:    state_next = lcpe_pkg::ST_PIN;
                        default:             state_next = lcpe_pkg::ST_CLEAR;
                    endcase
                end
            end
            lcpe_pkg::ST_ACC:
            begin
                if (!hit_any)
                begin
                    state_next = lcpe_pkg::ST_MISS;
                end
                else if (out_free)
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (hit[i])
                            rank_next[i] = '0;
                        else if (valid_reg[i] && rank_reg[i] < hit_rank)
                            rank_next[i] = rank_reg[i] + 1'b1;
                    end
                    out_valid_next = 1'b1;
                    kind_next      = lcpe_pkg::KIND_HIT;
                    rkey_next      = cur_reg.key;
                    ev_next        = 1'b0;
                    evkey_next     = '0;
                    last_next      = 1'b1;
                    state_next     = lcpe_pkg::ST_IDLE;
                end
            end
            lcpe_pkg::ST_MISS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rkey_next      = cur_reg.key;
                    ev_next        = 1'b0;
                    evkey_next     = '0;
                    last_next      = 1'b1;
                    kind_next      = lcpe_pkg::KIND_NO_ROOM;
                    state_next     = lcpe_pkg::ST_IDLE;
                    if (count_reg >= cap_eff)
                    begin
                        if (victim_any)
                        begin
                            // evict and reload in the victim's slot
                            for (int i = 0; i < N; i++)
                            begin
                                if (victim[i])
                                begin
                                    key_next[i]   = cur_reg.key;
                                    stamp_next[i] = cur_reg.now;
                                    rank_next[i]  = '0;
                                    epin_next[i]  = pin_hit;
                                end
                                else if (valid_reg[i] && rank_reg[i] < victim_rank)
                                begin
                                    rank_next[i] = rank_reg[i] + 1'b1;
                                end
                            end
                            kind_next  = lcpe_pkg::KIND_MISS;
                            ev_next    = 1'b1;
                            evkey_next = victim_key;
                        end
                    end
                    else if (free_any)
                    begin
                        for (int i = 0; i < N; i++)
                        begin
                            if (valid_reg[i])
                                rank_next[i] = rank_reg[i] + 1'b1;
                        end
                        key_next[free_idx]   = cur_reg.key;
                        stamp_next[free_idx] = cur_reg.now;
                        rank_next[free_idx]  = '0;
                        valid_next[free_idx] = 1'b1;
                        epin_next[free_idx]  = pin_hit;
                        count_next           = count_reg + 1'b1;
                        kind_next            = lcpe_pkg::KIND_MISS;
                    end
                end
            end
            lcpe_pkg::ST_PIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rkey_next      = cur_reg.key;
                    ev_next        = 1'b0;
                    evkey_next     = '0;
                    last_next      = 1'b1;
                    kind_next      = lcpe_pkg::KIND_PINNED;
                    state_next     = lcpe_pkg::ST_IDLE;
                    if (!pin_hit)
                    begin
                        if (pin_free_any)
                        begin
                            pvalid_next[pin_free_idx[$clog2(P)-1:0]] = 1'b1;
                            pkey_next[pin_free_idx[$clog2(P)-1:0]]   = cur_reg.key;
                            epin_next = epin_reg | hit;
                        end
                        else
                        begin
                            kind_next = lcpe_pkg::KIND_PIN_FULL;
                        end
                    end
                end
            end
            lcpe_pkg::ST_CLEAR:
            begin
                if (out_free)
                begin
                    pvalid_next    = '0;
                    epin_next      = '0;
                    out_valid_next = 1'b1;
                    kind_next      = lcpe_pkg::KIND_CLEARED;
                    rkey_next      = '0;
                    ev_next        = 1'b0;
                    evkey_next     = '0;
                    last_next      = 1'b1;
                    state_next     = lcpe_pkg::ST_IDLE;
                end
            end
            lcpe_pkg::ST_TICK:
            begin
                if (r_reg == end_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = pend_reg ? lcpe_pkg::KIND_EXPIRED
                                                  : lcpe_pkg::KIND_TICK_NONE;
                        rkey_next      = pend_reg ? pend_key_reg : '0;
                        ev_next        = 1'b0;
                        evkey_next     = '0;
                        last_next      = 1'b1;
                        state_next     = lcpe_pkg::ST_IDLE;
                    end
                end
                else if (expired)
                begin
                    // hold one expired word back so the final one carries last
                    if (!pend_reg || out_free)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = lcpe_pkg::KIND_EXPIRED;
                            rkey_next      = pend_key_reg;
                            ev_next        = 1'b0;
                            evkey_next     = '0;
                            last_next      = 1'b0;
                        end
                        pend_next     = 1'b1;
                        pend_key_next = tkey;
                        valid_next    = valid_reg & ~tsel;
                        count_next    = count_reg - 1'b1;
                        r_next        = r_reg + 1'b1;
                    end
                end
                else
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (tsel[i])
                            rank_next[i] = keep_reg[IW-1:0];
                    end
                    keep_next = keep_reg + 1'b1;
                    r_next    = r_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = lcpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcpe_pkg::ST_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            pvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            r_reg         <= '0;
            end_reg       <= '0;
            keep_reg      <= '0;
            cap_reg       <= lcpe_pkg::CAP_RESET;
            alive_reg     <= lcpe_pkg::ALIVE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            pvalid_reg    <= pvalid_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            r_reg         <= r_next;
            end_reg       <= end_next;
            keep_reg      <= keep_next;
            if (cfg_we)
            begin
                if (cfg_index == lcpe_pkg::CFG_CAPACITY)
                begin
                    if (cfg_data[lcpe_pkg::CAP_W-1:0] != '0)
                        cap_reg <= cfg_data[lcpe_pkg::CAP_W-1:0];
                end
                else if (cfg_index == lcpe_pkg::CFG_ALIVE)
                begin
                    alive_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        stamp_reg    <= stamp_next;
        rank_reg     <= rank_next;
        epin_reg     <= epin_next;
        pkey_reg     <= pkey_next;
        cur_reg      <= cur_next;
        pend_key_reg <= pend_key_next;
        kind_reg     <= kind_next;
        rkey_reg     <= rkey_next;
        ev_reg       <= ev_next;
        evkey_reg    <= evkey_next;
        last_reg     <= last_next;
    end

endmodule
`default_nettype wire

// ===== rtl/lru_cache_pinned_expiry.sv =====
`default_nettype none
// channel  | handshake            | words
// in       | in_valid / in_ready  | opcode, key, now
// out      | out_valid / out_ready| result_kind, result_key, evicted_valid, evicted_key, last
// cfg      | cfg_we               | cfg_index, cfg_data
//
// a two-word queue sits between the front and the execution engine
// an access goes from idle to a lookup state: a hit answers there, a miss moves on to the miss state
// a tick walks the entries held in rank order, one entry per cycle unless an expired one waits on a stalled output
// reset empties the cache and pin table, capacity 16, alive time 300
// a stalled output holds the engine; the queue keeps taking words until full
module lru_cache_pinned_expiry (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     opcode,
    input  wire logic [lcpe_pkg::KEY_W-1:0]     key,
    input  wire logic [lcpe_pkg::KEY_W-1:0]     now,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          result_kind,
    output logic [lcpe_pkg::KEY_W-1:0]          result_key,
    output logic                                evicted_valid,
    output logic [lcpe_pkg::KEY_W-1:0]          evicted_key,
    output logic                                last,
    input  wire logic                           cfg_we,
    input  wire logic [lcpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lcpe_pkg::KEY_W-1:0]     cfg_data
);

    lcpe_pkg::queue_out_t q;
    logic                 q_ready;

    lcpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .key      (key),
        .now      (now),
        .q_out    (q),
        .q_ready  (q_ready)
    );

    lcpe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_in          (q),
        .q_ready       (q_ready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .result_key    (result_key),
        .evicted_valid (evicted_valid),
        .evicted_key   (evicted_key),
        .last          (last)
    );

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;

    typedef struct packed {
        lcpe_pkg::kind_t kind;
        logic [31:0]     rkey;
        logic            ev;
        logic [31:0]     evkey;
        logic            lst;
    } word_t;

    localparam int WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = '0;
    logic [31:0] key = '0;
    logic [31:0] now = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  result_kind;
    logic [31:0] result_key;
    logic        evicted_valid;
    logic [31:0] evicted_key;
    logic        last;
    logic        cfg_we = 1'b0;
    logic [lcpe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    lru_cache_pinned_expiry dut (.*);

    always #4 clk = ~clk;

    // cache shadow
    logic [31:0] c_key [lcpe_pkg::ENTRIES];
    logic [31:0] c_stamp [lcpe_pkg::ENTRIES];
    bit          c_vld [lcpe_pkg::ENTRIES];
    int          c_rank [lcpe_pkg::ENTRIES];
    int          c_count;
    logic [31:0] p_key [lcpe_pkg::PIN_SLOTS];
    bit          p_vld [lcpe_pkg::PIN_SLOTS];
    logic [4:0]  cap_reg;
    logic [31:0] alive_reg;

    word_t pending_words[$];
    int    errors = 0;
    int    idle_cycles = 0;
    logic [31:0] clock_s = 32'd1000;
    logic [31:0] key_pool [8];
    bit    stall_free = 1'b0;

    function automatic bit pinned(logic [31:0] k);
        for (int i = 0; i < lcpe_pkg::PIN_SLOTS; i++)
            if (p_vld[i] && p_key[i] == k)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic word_t mk(lcpe_pkg::kind_t k, logic [31:0] rk, logic e,
                                 logic [31:0] ek, logic l);
        word_t w;
        w.kind = k; w.rkey = rk; w.ev = e; w.evkey = ek; w.lst = l;
        return w;
    endfunction

    task automatic predict_access(logic [31:0] k, logic [31:0] t);
        int slot, best, r, capn;
        logic e;
        logic [31:0] ek;
        slot = -1; e = 0; ek = 0;
        for (int i = 0; i < lcpe_pkg::ENTRIES; i++)
            if (c_vld[i] && c_key[i] == k)
            begin
                r = c_rank[i];
                for (int j = 0; j < lcpe_pkg::ENTRIES; j++)
                    if (c_vld[j] && c_rank[j] < r)
                        c_rank[j]++;
                c_rank[i] = 0;
                pending_words.push_back(mk(lcpe_pkg::KIND_HIT, k, 0, 0, 1));
                return;
            end
        capn = cap_reg < lcpe_pkg::ENTRIES ? cap_reg : lcpe_pkg::ENTRIES;
        if (c_count >= capn)
        begin
            best = -1;
            for (int i = 0; i < lcpe_pkg::ENTRIES; i++)
                if (c_vld[i] && !pinned(c_key[i]) && (best < 0 || c_rank[i] > c_rank[best]))
                    best = i;
            if (best < 0)
            begin
                pending_words.push_back(mk(lcpe_pkg::KIND_NO_ROOM, k, 0, 0, 1));
                return;
            end
            e = 1; ek = c_key[best];
            r = c_rank[best];
            c_vld[best] = 0;
            for (int i = 0; i < lcpe_pkg::ENTRIES; i++)
                if (c_vld[i] && c_rank[i] > r)
                    c_rank[i]--;
            c_count--;
            slot = best;
        end
        else
        begin
            for (int i = 0; i < lcpe_pkg::ENTRIES; i++)
                if (!c_vld[i] && slot < 0)
                    slot = i;
        end
        for (int i = 0; i < lcpe_pkg::ENTRIES; i++)
            if (c_vld[i])
                c_rank[i]++;
        c_key[slot] = k; c_stamp[slot] = t; c_rank[slot] = 0; c_vld[slot] = 1;
        c_count++;
        pending_words.push_back(mk(lcpe_pkg::KIND_MISS, k, e, ek, 1));
    endtask

    task automatic predict_tick(logic [31:0] t);
        int order[$];
        int keep, n;
        logic [31:0] lim;
        keep = 0; n = 0;
        for (int r = 0; r < lcpe_pkg::ENTRIES; r++)
            for (int i = 0; i < lcpe_pkg::ENTRIES; i++)
                if (c_vld[i] && c_rank[i] == r)
                begin
                    order.push_back(i);
                    break;
                end
        foreach (order[x])
        begin
            lim = c_stamp[order[x]] + alive_reg;
            if (lim < t && !pinned(c_key[order[x]]))
            begin
                c_vld[order[x]] = 0;
                c_count--;
                pending_words.push_back(mk(lcpe_pkg::KIND_EXPIRED, c_key[order[x]], 0, 0, 0));
                n++;
            end
            else
                c_rank[order[x]] = keep++;
        end
        if (n == 0)
            pending_words.push_back(mk(lcpe_pkg::KIND_TICK_NONE, 0, 0, 0, 1));
        else
            pending_words[$].lst = 1'b1;
    endtask

    task automatic predict_pin(logic [31:0] k);
        if (pinned(k))
        begin
            pending_words.push_back(mk(lcpe_pkg::KIND_PINNED, k, 0, 0, 1));
            return;
        end
        for (int i = 0; i < lcpe_pkg::PIN_SLOTS; i++)
            if (!p_vld[i])
            begin
                p_vld[i] = 1; p_key[i] = k;
                pending_words.push_back(mk(lcpe_pkg::KIND_PINNED, k, 0, 0, 1));
                return;
            end
        pending_words.push_back(mk(lcpe_pkg::KIND_PIN_FULL, k, 0, 0, 1));
    endtask

    // drop valid only when a gap follows
    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (stall_free)
            n = 0;
        if (n != 0)
        begin
            in_valid <= 1'b0;
            opcode <= 2'($urandom); key <= $urandom; now <= $urandom;
            repeat (n) @(negedge clk);
        end
    endtask

    // send one word and update the shadow
    task automatic send_word(lcpe_pkg::op_t op, logic [31:0] k, logic [31:0] t);
        gap();
        opcode <= op; key <= k; now <= t; in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (op)
            lcpe_pkg::OP_ACCESS: predict_access(k, t);
            lcpe_pkg::OP_TICK:   predict_tick(t);
            lcpe_pkg::OP_PIN:    predict_pin(k);
            default:
            begin
                foreach (p_vld[i])
                    p_vld[i] = 0;
                pending_words.push_back(mk(lcpe_pkg::KIND_CLEARED, 0, 0, 0, 1));
            end
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        opcode <= 2'($urandom); key <= $urandom; now <= $urandom;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [lcpe_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == lcpe_pkg::CFG_CAPACITY)
        begin
            if (v[4:0] != 0)
                cap_reg = v[4:0];
        end
        else
            alive_reg = v;
    endtask

    always @(posedge clk)
    begin
        word_t w;
        if (out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t unexpected word kind %0d key %h", $time, result_kind, result_key);
                errors++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (result_kind !== w.kind || result_key !== w.rkey ||
                    evicted_valid !== w.ev || evicted_key !== w.evkey || last !== w.lst)
                begin
                    $display("%0t mismatch exp kind %0d key %h ev %b evkey %h last %b",
                             $time, w.kind, w.rkey, w.ev, w.evkey, w.lst);
                    $display("%0t          got kind %0d key %h ev %b evkey %h last %b",
                             $time, result_kind, result_key, evicted_valid, evicted_key, last);
                    errors++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_free)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 19) == 0)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            out_ready <= ~out_ready;
        else
            out_ready <= 1'b1;
    end

    function automatic logic [31:0] pick_key();
        return ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
    endfunction

    task automatic test_directed();
        send_word(lcpe_pkg::OP_ACCESS, 32'h0, 32'h0);
        send_word(lcpe_pkg::OP_ACCESS, 32'h0, 32'h5);
        send_word(lcpe_pkg::OP_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(lcpe_pkg::OP_PIN, 32'h0, 32'h0);
        send_word(lcpe_pkg::OP_PIN, 32'h0, 32'h0);
        send_word(lcpe_pkg::OP_TICK, 32'h0, 32'hFFFF_FFFF);
        send_word(lcpe_pkg::OP_TICK, 32'h0, 32'h0);
        send_word(lcpe_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(lcpe_pkg::OP_TICK, 32'h0, 32'hFFFF_FFFF);
        for (int i = 0; i < 17; i++)
            send_word(lcpe_pkg::OP_PIN, 32'h100 + i, 32'h0);
        drain();
    endtask

    task automatic test_no_room();
        // everything held is pinned, so a miss finds no victim
        write_reg(lcpe_pkg::CFG_CAPACITY, 32'd2);
        send_word(lcpe_pkg::OP_ACCESS, 32'h100, 32'd10);
        send_word(lcpe_pkg::OP_ACCESS, 32'h101, 32'd10);
        send_word(lcpe_pkg::OP_ACCESS, 32'h200, 32'd10);
        send_word(lcpe_pkg::OP_CLEAR, 32'h0, 32'h0);
        send_word(lcpe_pkg::OP_ACCESS, 32'h200, 32'd10);
        drain();
        write_reg(lcpe_pkg::CFG_CAPACITY, 32'd0);
        write_reg(lcpe_pkg::CFG_CAPACITY, 32'd1);
        send_word(lcpe_pkg::OP_ACCESS, 32'h300, 32'd10);
        drain();
    endtask

    task automatic test_random(int n, logic [31:0] cap, logic [31:0] alive);
        int sel;
        write_reg(lcpe_pkg::CFG_CAPACITY, cap);
        write_reg(lcpe_pkg::CFG_ALIVE, alive);
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 19);
            clock_s += $urandom_range(0, 60);
            if (sel < 13)
                send_word(lcpe_pkg::OP_ACCESS, pick_key(), clock_s);
            else if (sel < 16)
                send_word(lcpe_pkg::OP_TICK, $urandom,
                          ($urandom_range(0, 15) == 0) ? $urandom : clock_s);
            else if (sel < 19)
                send_word(lcpe_pkg::OP_PIN, pick_key(), $urandom);
            else
                send_word(lcpe_pkg::OP_CLEAR, $urandom, $urandom);
            stall_free = (i % 40) >= 32;
        end
        stall_free = 0;
        drain();
    endtask

    initial
    begin
        cap_reg = lcpe_pkg::CAP_RESET;
        alive_reg = lcpe_pkg::ALIVE_RESET;
        c_count = 0;
        foreach (c_vld[i])
            c_vld[i] = 0;
        foreach (p_vld[i])
            p_vld[i] = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_no_room();
        test_random(50, 32'd4, 32'd100);
        test_random(50, 32'd16, 32'd0);
        test_random(34, 32'd31, 32'hFFFF_FFFF);
        test_random(44, 32'd3, 32'd40);
        test_random(50, 32'hFFFF_FFF7, 32'd250);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
